// ----- hdl/space_to_depth_nhwc_remap_top_assert.svh -----
// Assertion macros for the space-to-depth remap checker
`ifndef SPACE_TO_DEPTH_NHWC_REMAP_TOP_ASSERT_SVH
`define SPACE_TO_DEPTH_NHWC_REMAP_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define S2D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s2d assertion failed");

// next-cycle implication, disabled while in reset
`define S2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s2d assertion failed");

`endif

// ----- hdl/s2d_pkg.sv -----
// Package: widths, register indexes and reset values for the space-to-depth remap
`timescale 1ns / 1ps

package s2d_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int IDX_W          = 31;
    localparam int DIM_W          = 16;
    localparam int EDGE_W         = 7;
    localparam int OCH_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int DIV_STEP       = 4;
    localparam int OFF_W          = 13;
    localparam int OCHAN_W        = 30;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_EDGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_COLS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_CHANS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANS  = 3'd6;

    localparam logic [EDGE_W-1:0] RST_BLOCK_EDGE = 7'd2;
    localparam logic [DIM_W-1:0]  RST_IN_ROWS    = 16'd2;
    localparam logic [DIM_W-1:0]  RST_IN_COLS    = 16'd2;
    localparam logic [DIM_W-1:0]  RST_IN_CHANS   = 16'd1;
    localparam logic [DIM_W-1:0]  RST_OUT_ROWS   = 16'd1;
    localparam logic [DIM_W-1:0]  RST_OUT_COLS   = 16'd1;
    localparam logic [OCH_W-1:0]  RST_OUT_CHANS  = 24'd4;

endpackage

// ----- hdl/space_to_depth_nhwc_remap_top.sv -----
// Top level: space-to-depth NHWC index remap, divider chain and multiply pipeline
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------
//  input   | in_valid / in_stall  | src_index, elem_in
//  output  | out_valid / out_stall| dst_index, elem_out
//  config  | cfg_we (no stall)    | cfg_index, cfg_data
//
// One request per cycle while not stalled; 8+8+8+4 divider stages plus 4 multiply/add stages.
// The whole pipeline advances together; it freezes only when the output holds a
// request that is stalled, and in_stall is raised for exactly those cycles.
// Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps

module space_to_depth_nhwc_remap_top #(
    parameter int ELEM_WIDTH = s2d_pkg::ELEM_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [s2d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [s2d_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [s2d_pkg::IDX_W-1:0]       src_index,
    input  logic [ELEM_WIDTH-1:0]           elem_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [s2d_pkg::IDX_W-1:0]       dst_index,
    output logic [ELEM_WIDTH-1:0]           elem_out
);

    import s2d_pkg::*;

    logic [EDGE_W-1:0] block_edge_reg;
    logic [DIM_W-1:0]  in_rows_reg, in_cols_reg, in_chans_reg;
    logic [DIM_W-1:0]  out_rows_reg, out_cols_reg;
    logic [OCH_W-1:0]  out_chans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_edge_reg <= RST_BLOCK_EDGE;
            in_rows_reg    <= RST_IN_ROWS;
            in_cols_reg    <= RST_IN_COLS;
            in_chans_reg   <= RST_IN_CHANS;
            out_rows_reg   <= RST_OUT_ROWS;
            out_cols_reg   <= RST_OUT_COLS;
            out_chans_reg  <= RST_OUT_CHANS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_EDGE: block_edge_reg <= cfg_data[EDGE_W-1:0];
                REG_IN_ROWS:    in_rows_reg    <= cfg_data[DIM_W-1:0];
                REG_IN_COLS:    in_cols_reg    <= cfg_data[DIM_W-1:0];
                REG_IN_CHANS:   in_chans_reg   <= cfg_data[DIM_W-1:0];
                REG_OUT_ROWS:   out_rows_reg   <= cfg_data[DIM_W-1:0];
                REG_OUT_COLS:   out_cols_reg   <= cfg_data[DIM_W-1:0];
                REG_OUT_CHANS:  out_chans_reg  <= cfg_data[OCH_W-1:0];
                default:        ;
            endcase
        end
    end

    // zero divisors act as one
    logic [EDGE_W-1:0] be;
    logic [DIM_W-1:0]  ch, cw, rh;
    assign be = (block_edge_reg == '0) ? EDGE_W'(1) : block_edge_reg;
    assign ch = (in_chans_reg == '0) ? DIM_W'(1) : in_chans_reg;
    assign cw = (in_cols_reg == '0) ? DIM_W'(1) : in_cols_reg;
    assign rh = (in_rows_reg == '0) ? DIM_W'(1) : in_rows_reg;

    logic en;
    logic v4_reg;
    assign en       = !(v4_reg && out_stall);
    assign in_stall = !en;

    // channel split
    logic                  v1;
    logic [IDX_W-1:0]      q1;
    logic [DIM_W-1:0]      chan1;
    logic [ELEM_WIDTH-1:0] e1;

    s2d_div #(.NW(IDX_W), .DW(DIM_W), .SW(ELEM_WIDTH), .STEP(DIV_STEP)) u_div_chan (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_valid), .num(src_index), .den(ch), .side_in(elem_in),
        .out_valid(v1), .quo(q1), .rem(chan1), .side_out(e1)
    );

    // column split
    logic                           v2;
    logic [IDX_W-1:0]               q2;
    logic [DIM_W-1:0]               col2;
    logic [ELEM_WIDTH+DIM_W-1:0]    sd2;

    s2d_div #(.NW(IDX_W), .DW(DIM_W), .SW(ELEM_WIDTH+DIM_W), .STEP(DIV_STEP)) u_div_col (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1), .num(q1), .den(cw), .side_in({e1, chan1}),
        .out_valid(v2), .quo(q2), .rem(col2), .side_out(sd2)
    );

    // row split
    logic                            v3;
    logic [IDX_W-1:0]                batch3;
    logic [DIM_W-1:0]                row3;
    logic [ELEM_WIDTH+2*DIM_W-1:0]   sd3;

    s2d_div #(.NW(IDX_W), .DW(DIM_W), .SW(ELEM_WIDTH+2*DIM_W), .STEP(DIV_STEP)) u_div_row (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2), .num(q2), .den(rh), .side_in({sd2, col2}),
        .out_valid(v3), .quo(batch3), .rem(row3), .side_out(sd3)
    );

    logic [ELEM_WIDTH-1:0] e3;
    logic [DIM_W-1:0]      chan3, col3;
    assign {e3, chan3, col3} = sd3;

    // block splits of row and column
    logic                          v4a, v4b;
    logic [DIM_W-1:0]              orow4, ocol4;
    logic [EDGE_W-1:0]             roff4, coff4;
    logic [ELEM_WIDTH+IDX_W-1:0]   sd4a;
    logic [DIM_W-1:0]              chan4;

    s2d_div #(.NW(DIM_W), .DW(EDGE_W), .SW(ELEM_WIDTH+IDX_W), .STEP(DIV_STEP)) u_div_brow (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v3), .num(row3), .den(be), .side_in({e3, batch3}),
        .out_valid(v4a), .quo(orow4), .rem(roff4), .side_out(sd4a)
    );

    s2d_div #(.NW(DIM_W), .DW(EDGE_W), .SW(DIM_W), .STEP(DIV_STEP)) u_div_bcol (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v3), .num(col3), .den(be), .side_in(chan3),
        .out_valid(v4b), .quo(ocol4), .rem(coff4), .side_out(chan4)
    );

    logic [ELEM_WIDTH-1:0] e4;
    logic [IDX_W-1:0]      batch4;
    assign {e4, batch4} = sd4a;

    // multiply stages
    logic                  v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]      t0_reg, t1_reg, t2_reg, dst_reg;
    logic [OFF_W-1:0]      off_reg;
    logic [DIM_W-1:0]      ocol_reg, chan_reg;
    logic [OCHAN_W-1:0]    ochan2_reg, ochan3_reg;
    logic [ELEM_WIDTH-1:0] em1_reg, em2_reg, em3_reg, em4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v4a && v4b;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg     <= IDX_W'(IDX_W'(orow4) + IDX_W'(out_rows_reg * batch4));
            off_reg    <= OFF_W'(roff4) * OFF_W'(be) + OFF_W'(coff4);
            ocol_reg   <= ocol4;
            chan_reg   <= chan4;
            em1_reg    <= e4;

            t1_reg     <= IDX_W'(IDX_W'(ocol_reg) + IDX_W'(out_cols_reg * t0_reg));
            ochan2_reg <= OCHAN_W'(chan_reg) + OCHAN_W'(off_reg) * OCHAN_W'(in_chans_reg);
            em2_reg    <= em1_reg;

            t2_reg     <= IDX_W'(out_chans_reg * t1_reg);
            ochan3_reg <= ochan2_reg;
            em3_reg    <= em2_reg;

            dst_reg    <= IDX_W'(IDX_W'(ochan3_reg) + t2_reg);
            em4_reg    <= em3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign dst_index = dst_reg;
    assign elem_out  = em4_reg;

endmodule

// ----- hdl/s2d_div.sv -----
// Pipelined restoring divider, STEP quotient bits per stage, with sideband payload
`timescale 1ns / 1ps

module s2d_div #(
    parameter int NW   = 31,
    parameter int DW   = 16,
    parameter int SW   = 32,
    parameter int STEP = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [SW-1:0] side_out
);

    localparam int NS = (NW + STEP - 1) / STEP;
    localparam int PW = NS * STEP;

    logic [PW-1:0] q_reg [NS];
    logic [DW-1:0] r_reg [NS];
    logic [SW-1:0] s_reg [NS];
    logic          v_reg [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            logic [PW-1:0] q_cur;
            logic [DW-1:0] r_cur;
            logic [SW-1:0] s_cur;
            logic          v_cur;
            logic [PW-1:0] q_next;
            logic [DW-1:0] r_next;

            if (s == 0)
            begin : g_first
                assign q_cur = PW'(num);
                assign r_cur = '0;
                assign s_cur = side_in;
                assign v_cur = in_valid;
            end
            else
            begin : g_rest
                assign q_cur = q_reg[s-1];
                assign r_cur = r_reg[s-1];
                assign s_cur = s_reg[s-1];
                assign v_cur = v_reg[s-1];
            end

            always_comb
            begin
                logic [DW:0] r_ext;
                q_next = q_cur;
                r_next = r_cur;
                for (int i = 0; i < STEP; i++)
                begin
                    r_ext  = {r_next, q_next[PW-1]};
                    q_next = {q_next[PW-2:0], 1'b0};
                    if (r_ext >= {1'b0, den})
                    begin
                        r_ext     = r_ext - {1'b0, den};
                        q_next[0] = 1'b1;
                    end
                    r_next = r_ext[DW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[s] <= v_cur;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[s] <= q_next;
                    r_reg[s] <= r_next;
                    s_reg[s] <= s_cur;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign quo       = q_reg[NS-1][NW-1:0];
    assign rem       = r_reg[NS-1];
    assign side_out  = s_reg[NS-1];

endmodule

// ----- hdl/s2d_checker.sv -----
// Port-level checker for the space-to-depth remap, bound to the top level
`timescale 1ns / 1ps
`include "space_to_depth_nhwc_remap_top_assert.svh"

module s2d_checker #(
    parameter int ELEM_WIDTH = s2d_pkg::ELEM_WIDTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [s2d_pkg::IDX_W-1:0]       dst_index,
    input logic [ELEM_WIDTH-1:0]           elem_out
);

    `S2D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `S2D_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(dst_index) && $stable(elem_out))
    `S2D_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    `S2D_ASSERT_NOW(a_stall_full, out_valid && out_stall, in_stall)
    `S2D_ASSERT_NOW(a_reset_empty, $rose(rst_n), !out_valid)

endmodule

bind space_to_depth_nhwc_remap_top s2d_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_s2d_checker (.*);

// ----- tb/sv/space_to_depth_nhwc_remap_top_tb.sv -----
// Testbench: space-to-depth NHWC remap, directed table plus random requests
`timescale 1ns / 1ps

module space_to_depth_nhwc_remap_top_tb;
    import s2d_pkg::*;

    localparam int EW = ELEM_WIDTH_DEF;
    localparam int LATENCY = 32;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1030;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [EW-1:0]    elem;
    } remap_t;

    typedef struct {
        logic [IDX_W-1:0] src;
        logic [EW-1:0]    elem;
        bit               has_exp;
        logic [IDX_W-1:0] exp_dst;
    } row_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [IDX_W-1:0] src_index, dst_index;
    logic [EW-1:0] elem_in, elem_out;

    space_to_depth_nhwc_remap_top dut (.*);

    // shadow registers
    logic [EDGE_W-1:0] m_edge;
    logic [DIM_W-1:0]  m_rows, m_cols, m_chans, m_orows, m_ocols;
    logic [OCH_W-1:0]  m_ochans;

    remap_t pending_q[$];
    int mismatches = 0, accepted_in = 0, accepted_out = 0, idle_cycles = 0;
    bit long_hold = 0;
    int phases = 0;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic logic [IDX_W-1:0] remap_index(logic [IDX_W-1:0] src);
        longint unsigned be, ch, cw, rh, chan, rest, col, row, batch, dst;
        be = (m_edge == 0) ? 1 : m_edge;
        ch = (m_chans == 0) ? 1 : m_chans;
        cw = (m_cols == 0) ? 1 : m_cols;
        rh = (m_rows == 0) ? 1 : m_rows;
        chan = src % ch;
        rest = src / ch;
        col = rest % cw;
        rest = rest / cw;
        row = rest % rh;
        batch = rest / rh;
        dst = chan + ((row % be) * be + (col % be)) * m_chans;
        dst = dst + m_ochans * ((col / be) + m_ocols * ((row / be) + m_orows * batch));
        return dst[IDX_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1;
        cfg_index <= r;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        case (r)
            REG_BLOCK_EDGE: m_edge = v[EDGE_W-1:0];
            REG_IN_ROWS:    m_rows = v[DIM_W-1:0];
            REG_IN_COLS:    m_cols = v[DIM_W-1:0];
            REG_IN_CHANS:   m_chans = v[DIM_W-1:0];
            REG_OUT_ROWS:   m_orows = v[DIM_W-1:0];
            REG_OUT_COLS:   m_ocols = v[DIM_W-1:0];
            REG_OUT_CHANS:  m_ochans = v[OCH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_shape(int be, int rows, int cols, int chans, bit consistent);
        write_reg(REG_BLOCK_EDGE, CFG_DATA_W'(be));
        write_reg(REG_IN_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_IN_COLS, CFG_DATA_W'(cols));
        write_reg(REG_IN_CHANS, CFG_DATA_W'(chans));
        if (consistent && be != 0)
        begin
            write_reg(REG_OUT_ROWS, CFG_DATA_W'(rows / be));
            write_reg(REG_OUT_COLS, CFG_DATA_W'(cols / be));
            write_reg(REG_OUT_CHANS, CFG_DATA_W'(chans * be * be));
        end
        else
        begin
            write_reg(REG_OUT_ROWS, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_OUT_COLS, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_OUT_CHANS, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic send_request(logic [IDX_W-1:0] s, logic [EW-1:0] e, bit gaps);
        remap_t r;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1;
        src_index <= s;
        elem_in <= e;
        r.idx = remap_index(s);
        r.elem = e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_q.push_back(r);
        accepted_in++;
        @(negedge clk);
    endtask

    // receiver
    initial
    begin
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1;
                repeat (200) @(negedge clk);
                long_hold = 0;
                out_stall <= 0;
            end
            else if (phases % 3 == 2)
                out_stall <= 0;
            else if ($urandom_range(0, 30) == 0)
                out_stall <= 1;
            else if ($urandom_range(0, 3) == 0)
                out_stall <= ~out_stall;
        end
    end

    // checker and watchdog
    always @(posedge clk)
    begin
        remap_t e;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG)
            begin
                $display("watchdog expired: %0d outstanding", pending_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                accepted_out++;
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result dst=%h", dst_index);
                end
                else
                begin
                    e = pending_q.pop_front();
                    if (e.idx !== dst_index || e.elem !== elem_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: dst exp %h got %h, elem exp %h got %h",
                                     e.idx, dst_index, e.elem, elem_out);
                    end
                end
            end
        end
    end

    initial
    begin
        row_t dir[$];
        int be;
        logic [IDX_W-1:0] s;
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; src_index = '0; elem_in = '0;
        m_edge = RST_BLOCK_EDGE; m_rows = RST_IN_ROWS; m_cols = RST_IN_COLS;
        m_chans = RST_IN_CHANS; m_orows = RST_OUT_ROWS; m_ocols = RST_OUT_COLS;
        m_ochans = RST_OUT_CHANS;
        rst_n = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset shape 2x2x1 -> 1x1x4: index i maps to i within the first batch
        dir.push_back('{31'd0, 32'h0, 1, 31'd0});
        dir.push_back('{31'd1, 32'hFFFFFFFF, 1, 31'd1});
        dir.push_back('{31'd2, 32'h55555555, 1, 31'd2});
        dir.push_back('{31'd3, 32'hAAAAAAAA, 1, 31'd3});
        dir.push_back('{31'd4, 32'h1, 1, 31'd4});
        dir.push_back('{31'h7FFFFFFF, 32'h80000000, 0, '0});
        dir.push_back('{31'h40000000, 32'h7FFFFFFF, 0, '0});
        foreach (dir[i])
        begin
            send_request(dir[i].src, dir[i].elem, 0);
            if (dir[i].has_exp && remap_index(dir[i].src) != dir[i].exp_dst)
            begin
                mismatches++;
                $display("directed row %0d disagrees with predictor", i);
            end
        end
        wait_drained();

        // zero divisors, edge 64, max dims, inconsistent output dims
        dir.delete();
        for (int k = 0; k < 6; k++)
            dir.push_back('{IDX_W'($urandom), $urandom, 0, '0});
        set_shape(0, 0, 0, 0, 0);
        foreach (dir[i]) send_request(dir[i].src, dir[i].elem, 0);
        wait_drained();
        set_shape(64, 65535, 65535, 65535, 0);
        write_reg(REG_OUT_CHANS, 24'hFFFFFF);
        write_reg(REG_OUT_ROWS, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_OUT_COLS, CFG_DATA_W'(16'hFFFF));
        send_request(31'h7FFFFFFF, 32'hFFFFFFFF, 0);
        send_request(31'h0, 32'h0, 0);
        foreach (dir[i]) send_request(dir[i].src, dir[i].elem, 0);
        wait_drained();

        // random phases
        for (int ph = 0; ph < 10; ph++)
        begin
            phases = ph;
            be = (ph == 0) ? 2 : (ph == 1) ? 64 : $urandom_range(2, 8);
            set_shape(be, be * $urandom_range(1, 6), be * $urandom_range(1, 6),
                      (ph == 3) ? 65535 : $urandom_range(1, 9), ph % 4 != 3);
            if (ph == 4) long_hold = 1;
            for (int k = 0; k < N_RANDOM / 10; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    s = IDX_W'($urandom);
                else
                    s = IDX_W'($urandom_range(0, 4 * m_rows * m_cols * m_chans - 1));
                send_request(s, $urandom, ph % 3 != 2);
            end
            wait_drained();
        end

        $display("%0d requests sent, %0d results checked, edges 0..64, zero and max dims",
                 accepted_in, accepted_out);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
